@@ sv/erd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_pkg
// Shared types and constants of the escaped record deframer.
// ----------------------------------------------------------------------------
package erd_pkg;

  localparam int RecordBytesDefault = 64;
  localparam int LenW               = 7;

  localparam logic [1:0] CFG_FRAME_BYTE  = 2'd0;
  localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd1;
  localparam logic [1:0] CFG_ESCAPE_MASK = 2'd2;
  localparam logic [1:0] CFG_GOOD_SUM    = 2'd3;

  localparam logic [7:0] FRAME_BYTE_RST  = 8'd126;
  localparam logic [7:0] ESCAPE_BYTE_RST = 8'd125;
  localparam logic [7:0] ESCAPE_MASK_RST = 8'd32;
  localparam logic [7:0] GOOD_SUM_RST    = 8'd255;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CHECKSUM = 2'd1,
    STATUS_SHORT    = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [7:0]       data;
    logic             last;
    logic             seq_gap;
    logic [LenW-1:0]  length;
  } result_t;

endpackage

@@ sv/erd_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_store
// Record byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module erd_store import erd_pkg::*; #(
  parameter int RecordBytes = RecordBytesDefault,
  parameter int AddrW       = $clog2(RecordBytes)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [RecordBytes];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/erd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_ctrl
// Byte decoder, checksum, fill count and record readout sequencer.
// ----------------------------------------------------------------------------
module erd_ctrl import erd_pkg::*; #(
  parameter int RecordBytes = RecordBytesDefault,
  parameter int AddrW       = $clog2(RecordBytes),
  parameter int CntW        = $clog2(RecordBytes + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  output logic             in_ready_o,
  input  logic             pend_free_i,
  output logic             res_valid_o,
  output result_t          res_o,
  output logic             we_o,
  output logic [AddrW-1:0] waddr_o,
  output logic [7:0]       wdata_o,
  output logic             re_o,
  output logic [AddrW-1:0] raddr_o,
  input  logic [7:0]       rdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_LD   = 2'd2;

  localparam logic [CntW-1:0] FullCount = CntW'(RecordBytes);

  logic [1:0]       state_q, state_d;
  logic             esc_q, esc_d;
  logic [7:0]       sum_q, sum_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [7:0]       lseq_q, lseq_d;
  logic             gap_q, gap_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]       frame_q, escape_q, mask_q, good_q;

  logic       acc;
  logic       do_store;
  logic [7:0] store_val;
  logic       gap_now;
  logic       last_now;

  always_comb begin
    state_d     = state_q;
    esc_d       = esc_q;
    sum_d       = sum_q;
    fill_d      = fill_q;
    lseq_d      = lseq_q;
    gap_d       = gap_q;
    rd_idx_d    = rd_idx_q;
    res_valid_o = 1'b0;
    res_o       = '{status: STATUS_OK, data: 8'd0, last: 1'b1, seq_gap: 1'b0,
                    length: LenW'(fill_q)};
    we_o        = 1'b0;
    waddr_o     = fill_q[AddrW-1:0];
    wdata_o     = 8'd0;
    re_o        = 1'b0;
    raddr_o     = rd_idx_q;
    do_store    = 1'b0;
    store_val   = in_byte_i;
    in_ready_o  = (state_q == ST_IDLE) && pend_free_i;
    acc         = in_valid_i && in_ready_o;
    gap_now     = (rd_idx_q == '0) ? (rdata_i != (lseq_q + 8'd1)) : gap_q;
    last_now    = ((CntW'(rd_idx_q) + CntW'(1)) == fill_q);

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (esc_q) begin
            esc_d     = 1'b0;
            do_store  = 1'b1;
            store_val = in_byte_i ^ mask_q;
          end else if (in_byte_i == escape_q) begin
            esc_d = 1'b1;
          end else if (in_byte_i == frame_q) begin
            sum_d = 8'd0;
            esc_d = 1'b0;
            if (sum_q != good_q) begin
              res_valid_o   = 1'b1;
              res_o.status  = STATUS_CHECKSUM;
              fill_d        = '0;
            end else if (fill_q < CntW'(3)) begin
              res_valid_o   = 1'b1;
              res_o.status  = STATUS_SHORT;
              fill_d        = '0;
            end else begin
              rd_idx_d = '0;
              state_d  = ST_RD;
            end
          end else begin
            do_store = 1'b1;
          end
        end
        if (do_store) begin
          if (fill_q == FullCount) begin
            res_valid_o  = 1'b1;
            res_o.status = STATUS_OVERFLOW;
            res_o.length = LenW'(RecordBytes);
            sum_d        = 8'd0;
            fill_d       = '0;
            esc_d        = 1'b0;
          end else begin
            sum_d   = sum_q + store_val;
            we_o    = 1'b1;
            wdata_o = store_val;
            fill_d  = fill_q + CntW'(1);
          end
        end
      end
      ST_RD: begin
        re_o    = 1'b1;
        state_d = ST_LD;
      end
      ST_LD: begin
        if (pend_free_i) begin
          res_valid_o   = 1'b1;
          res_o.status  = STATUS_OK;
          res_o.data    = rdata_i;
          res_o.last    = last_now;
          res_o.seq_gap = gap_now;
          gap_d         = gap_now;
          if (rd_idx_q == '0) begin
            lseq_d = rdata_i;
          end
          if (last_now) begin
            fill_d  = '0;
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + AddrW'(1);
            state_d  = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      esc_q    <= 1'b0;
      sum_q    <= 8'd0;
      fill_q   <= '0;
      lseq_q   <= 8'd0;
      gap_q    <= 1'b0;
      rd_idx_q <= '0;
      frame_q  <= FRAME_BYTE_RST;
      escape_q <= ESCAPE_BYTE_RST;
      mask_q   <= ESCAPE_MASK_RST;
      good_q   <= GOOD_SUM_RST;
    end else begin
      state_q  <= state_d;
      esc_q    <= esc_d;
      sum_q    <= sum_d;
      fill_q   <= fill_d;
      lseq_q   <= lseq_d;
      gap_q    <= gap_d;
      rd_idx_q <= rd_idx_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_FRAME_BYTE:  frame_q  <= cfg_data_i;
          CFG_ESCAPE_BYTE: escape_q <= cfg_data_i;
          CFG_ESCAPE_MASK: mask_q   <= cfg_data_i;
          CFG_GOOD_SUM:    good_q   <= cfg_data_i;
          default:         frame_q  <= frame_q;
        endcase
      end
    end
  end

endmodule

@@ sv/erd_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_out
// Two-entry result queue: a pending slot in front of the output register.
// ----------------------------------------------------------------------------
module erd_out import erd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    pend_free_o,
  output logic    out_valid_o,
  output result_t out_o,
  input  logic    out_ready_i
);

  logic    pend_valid_q;
  result_t pend_q;
  logic    out_valid_q;
  result_t out_q;
  logic    pend_take;

  assign pend_take   = pend_valid_q && (!out_valid_q || out_ready_i);
  assign pend_free_o = !pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (res_valid_i) begin
        pend_valid_q <= 1'b1;
      end else if (pend_take) begin
        pend_valid_q <= 1'b0;
      end
      if (pend_take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      pend_q <= res_i;
    end
    if (pend_take) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ sv/escaped_record_deframer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_record_deframer_unit
// Byte-stuffed record receiver with additive checksum and sequence check.
// ----------------------------------------------------------------------------
// Link bytes enter on the s_axis channel, one byte per request in tdata.
// Results leave on the m_axis channel; tlast marks the final result caused
// by one input byte. The cfg channel writes frame byte, escape byte, escape
// mask and good checksum by index and is always ready.
// Data and escape bytes that give no result are taken without leaving idle.
// A byte that gives a single error or overflow result puts it in the pending
// slot as the byte is accepted; it then passes the output register to m_axis.
// A good record is read back from the record memory byte by byte, each byte
// in a memory read state and then a state that loads the result queue, so
// the input is held from its frame byte until the last byte is loaded; the
// load state waits while the pending slot is full.
// A result queue of two entries parts the sides: input bytes are still
// taken while one result waits on a stalled receiver, and the input stalls
// once the second entry is filled and while a record is read back.
// Reset restores the register defaults and clears checksum, fill count,
// escape flag and last sequence; the record memory needs no clearing.
// ----------------------------------------------------------------------------
module escaped_record_deframer_unit import erd_pkg::*; #(
  parameter int RecordBytes = RecordBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] status, [9:2] data, [10] seq_gap,
                                      // [17:11] length, [23:18] zero
  output logic        m_axis_tlast
);

  localparam int AddrW = $clog2(RecordBytes);

  logic             pend_free;
  logic             res_valid;
  result_t          res;
  result_t          out_res;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [7:0]       wdata;
  logic             re;
  logic [AddrW-1:0] raddr;
  logic [7:0]       rdata;

  assign cfg_ready_o = 1'b1;

  erd_ctrl #(
    .RecordBytes(RecordBytes)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .pend_free_i(pend_free),
    .res_valid_o(res_valid),
    .res_o      (res),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  erd_store #(
    .RecordBytes(RecordBytes)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  erd_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .pend_free_o(pend_free),
    .out_valid_o(m_axis_tvalid),
    .out_o      (out_res),
    .out_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, out_res.length, out_res.seq_gap, out_res.data,
                         out_res.status};
  assign m_axis_tlast = out_res.last;

endmodule

@@ sv/erd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_checker
// Port-level checks of the result stream of the escaped record deframer.
// ----------------------------------------------------------------------------
module erd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  property p_hold_valid;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid;
  endproperty
  a_hold_valid: assert property (p_hold_valid) else $error("result request dropped");

  property p_error_single;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0) |->
        m_axis_tlast && (m_axis_tdata[9:2] == 8'd0);
  endproperty
  a_error_single: assert property (p_error_single)
    else $error("error result not a single zero-data request");

  property p_error_nogap;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0) |-> !m_axis_tdata[10];
  endproperty
  a_error_nogap: assert property (p_error_nogap) else $error("gap flag on error result");

  property p_pad_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> (m_axis_tdata[23:18] == 6'd0);
  endproperty
  a_pad_zero: assert property (p_pad_zero) else $error("padding bits not zero");

endmodule

bind escaped_record_deframer_unit erd_checker u_erd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
